@@ rtl/core/hlcd_pkg.sv @@
// ----------------------------------------------------------------------------
// hlcd_pkg
// shared types, codes and reset values of the header/length/checksum deframer
// ----------------------------------------------------------------------------
package hlcd_pkg;

	localparam int CNT_W   = 16;
	localparam int CNT_OUT_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_HEADER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ASYNC_HEADER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH   = 2'd2;

	localparam logic [7:0] SYNC_HDR_DEFAULT  = 8'd35;
	localparam logic [7:0] ASYNC_HDR_DEFAULT = 8'd42;
	localparam logic [7:0] MAX_LEN_DEFAULT   = 8'd255;

	localparam logic [2:0] ST_CONSUMED = 3'd0;
	localparam logic [2:0] ST_PAYLOAD  = 3'd1;
	localparam logic [2:0] ST_GOOD     = 3'd2;
	localparam logic [2:0] ST_HDR_ERR  = 3'd3;
	localparam logic [2:0] ST_LEN_ERR  = 3'd4;
	localparam logic [2:0] ST_CKS_ERR  = 3'd5;

	typedef struct packed {
		logic [7:0] sync_header;
		logic [7:0] async_header;
		logic [7:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} stage_t;

endpackage

@@ rtl/core/hlcd_if.sv @@
// ----------------------------------------------------------------------------
// hlcd_if
// valid/ready channels for received bytes and parser results
// ----------------------------------------------------------------------------
interface hlcd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface hlcd_result_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    status;
	logic [7:0]                    payload_byte;
	logic [7:0]                    payload_index;
	logic                          frame_is_async;
	logic [7:0]                    frame_length;
	logic [hlcd_pkg::CNT_OUT_W-1:0] header_error_count;
	logic [hlcd_pkg::CNT_OUT_W-1:0] length_error_count;
	logic [hlcd_pkg::CNT_OUT_W-1:0] checksum_error_count;

	modport source (output valid, output status, output payload_byte, output payload_index,
		output frame_is_async, output frame_length, output header_error_count,
		output length_error_count, output checksum_error_count, input ready);
	modport sink (input valid, input status, input payload_byte, input payload_index,
		input frame_is_async, input frame_length, input header_error_count,
		input length_error_count, input checksum_error_count, output ready);
endinterface

@@ rtl/core/header_length_checksum_deframer.sv @@
// path: an accepted byte is held in the input register, then parsed into the result register
// throughput: one byte per cycle while results are taken, set by the parser update
// a stalled result holds one byte in the input register, then back-pressures
// reset: asynchronous, clears parser state, error counters and valids,
// and loads the header and length registers with their defaults
// ----------------------------------------------------------------------------
// header_length_checksum_deframer
// byte-serial frame parser with additive checksum and error counters
// ----------------------------------------------------------------------------
module header_length_checksum_deframer (
	input  logic                           clk,
	input  logic                           arst_n,
	hlcd_byte_if.sink                      rx,
	hlcd_result_if.source                  res,
	input  logic                           cfg_we,
	input  logic [hlcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data
);

	hlcd_pkg::cfg_t   cfg;
	hlcd_pkg::stage_t stage;
	logic             take;

	hlcd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hlcd_in_stage u_in (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.take   (take),
		.stage  (stage)
	);

	hlcd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.stage  (stage),
		.take   (take),
		.res    (res)
	);

endmodule

@@ rtl/core/hlcd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// hlcd_cfg_regs
// write-only configuration registers: header values and length limit
// ----------------------------------------------------------------------------
module hlcd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hlcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	output hlcd_pkg::cfg_t                 cfg
);

	hlcd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_header  <= hlcd_pkg::SYNC_HDR_DEFAULT;
			cfg_q.async_header <= hlcd_pkg::ASYNC_HDR_DEFAULT;
			cfg_q.max_length   <= hlcd_pkg::MAX_LEN_DEFAULT;
		end else if (cfg_we) begin
			case (cfg_index)
				hlcd_pkg::REG_SYNC_HEADER:  cfg_q.sync_header  <= cfg_data;
				hlcd_pkg::REG_ASYNC_HEADER: cfg_q.async_header <= cfg_data;
				hlcd_pkg::REG_MAX_LENGTH:   cfg_q.max_length   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/hlcd_in_stage.sv @@
// ----------------------------------------------------------------------------
// hlcd_in_stage
// input register for received bytes, refilled in the cycle it drains
// ----------------------------------------------------------------------------
module hlcd_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	hlcd_byte_if.sink       rx,
	input  logic            take,
	output hlcd_pkg::stage_t stage
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	assign rx.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign stage.valid   = valid_s1;
	assign stage.rx_byte = byte_s1;

endmodule

@@ rtl/core/hlcd_parser.sv @@
// ----------------------------------------------------------------------------
// hlcd_parser
// frame state machine, checksum, error counters and result register
// ----------------------------------------------------------------------------
module hlcd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  hlcd_pkg::cfg_t   cfg,
	input  hlcd_pkg::stage_t stage,
	output logic             take,
	hlcd_result_if.source    res
);

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_LENGTH = 2'd1,
		PH_DATA   = 2'd2
	} phase_t;

	localparam logic [hlcd_pkg::CNT_W-1:0] CNT_MAX = '1;

	phase_t                     phase_q, phase_d;
	logic                       async_q, async_d;
	logic [7:0]                 len_q, len_d;
	logic [7:0]                 rcvd_q, rcvd_d;
	logic [7:0]                 sum_q, sum_d;
	logic [hlcd_pkg::CNT_W-1:0] hdr_cnt_q, hdr_cnt_d;
	logic [hlcd_pkg::CNT_W-1:0] len_cnt_q, len_cnt_d;
	logic [hlcd_pkg::CNT_W-1:0] cks_cnt_q, cks_cnt_d;
	logic [2:0]                 status_d, status_q;
	logic [7:0]                 pbyte_d, pbyte_q;
	logic [7:0]                 pindex_d, pindex_q;
	logic                       out_valid_q;
	logic [31:0]                hdr_ext, len_ext, cks_ext;
	logic [7:0]                 b;

	assign b    = stage.rx_byte;
	assign take = stage.valid && (!out_valid_q || res.ready);

	always_comb begin
		phase_d   = phase_q;
		async_d   = async_q;
		len_d     = len_q;
		rcvd_d    = rcvd_q;
		sum_d     = sum_q;
		hdr_cnt_d = hdr_cnt_q;
		len_cnt_d = len_cnt_q;
		cks_cnt_d = cks_cnt_q;
		status_d  = hlcd_pkg::ST_CONSUMED;
		pbyte_d   = 8'd0;
		pindex_d  = 8'd0;
		case (phase_q)
			PH_LENGTH: begin
				if (b > cfg.max_length) begin
					status_d = hlcd_pkg::ST_LEN_ERR;
					if (len_cnt_q != CNT_MAX) len_cnt_d = len_cnt_q + 1'b1;
					phase_d = PH_HEADER;
				end else begin
					len_d   = b;
					rcvd_d  = 8'd0;
					sum_d   = 8'd0;
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				if (rcvd_q == len_q) begin
					phase_d = PH_HEADER;
					if (sum_q == b) begin
						status_d = hlcd_pkg::ST_GOOD;
					end else begin
						status_d = hlcd_pkg::ST_CKS_ERR;
						if (cks_cnt_q != CNT_MAX) cks_cnt_d = cks_cnt_q + 1'b1;
					end
				end else begin
					status_d = hlcd_pkg::ST_PAYLOAD;
					pbyte_d  = b;
					pindex_d = rcvd_q;
					sum_d    = sum_q + b;
					rcvd_d   = rcvd_q + 8'd1;
				end
			end
			default: begin
				if (b == cfg.sync_header) begin
					async_d = 1'b0;
					phase_d = PH_LENGTH;
				end else if (b == cfg.async_header) begin
					async_d = 1'b1;
					phase_d = PH_LENGTH;
				end else begin
					status_d = hlcd_pkg::ST_HDR_ERR;
					if (hdr_cnt_q != CNT_MAX) hdr_cnt_d = hdr_cnt_q + 1'b1;
					phase_d = PH_HEADER;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			async_q     <= 1'b0;
			len_q       <= 8'd0;
			rcvd_q      <= 8'd0;
			sum_q       <= 8'd0;
			hdr_cnt_q   <= '0;
			len_cnt_q   <= '0;
			cks_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			status_q    <= hlcd_pkg::ST_CONSUMED;
			pbyte_q     <= 8'd0;
			pindex_q    <= 8'd0;
		end else if (take) begin
			phase_q     <= phase_d;
			async_q     <= async_d;
			len_q       <= len_d;
			rcvd_q      <= rcvd_d;
			sum_q       <= sum_d;
			hdr_cnt_q   <= hdr_cnt_d;
			len_cnt_q   <= len_cnt_d;
			cks_cnt_q   <= cks_cnt_d;
			out_valid_q <= 1'b1;
			status_q    <= status_d;
			pbyte_q     <= pbyte_d;
			pindex_q    <= pindex_d;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// state only moves with a new result, so it doubles as the reported fields
	assign hdr_ext = 32'(hdr_cnt_q);
	assign len_ext = 32'(len_cnt_q);
	assign cks_ext = 32'(cks_cnt_q);

	assign res.valid                = out_valid_q;
	assign res.status               = status_q;
	assign res.payload_byte         = pbyte_q;
	assign res.payload_index        = pindex_q;
	assign res.frame_is_async       = async_q;
	assign res.frame_length         = len_q;
	assign res.header_error_count   = hdr_ext[hlcd_pkg::CNT_OUT_W-1:0];
	assign res.length_error_count   = len_ext[hlcd_pkg::CNT_OUT_W-1:0];
	assign res.checksum_error_count = cks_ext[hlcd_pkg::CNT_OUT_W-1:0];

`ifndef SYNTH
	a_payload_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == hlcd_pkg::ST_PAYLOAD) |-> (pindex_q < len_q))
		else $error("payload index not below frame length");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(take && status_d == hlcd_pkg::ST_PAYLOAD) |=> (rcvd_q == $past(rcvd_q) + 8'd1))
		else $error("received count did not advance on payload byte");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> ($stable(phase_q) && $stable(sum_q) && $stable(hdr_cnt_q)))
		else $error("parser state moved without a byte");

	a_hdr_err_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(take && status_d == hlcd_pkg::ST_HDR_ERR && hdr_cnt_q != CNT_MAX)
		|=> (hdr_cnt_q == $past(hdr_cnt_q) + 1'b1))
		else $error("header error not counted");
`endif

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream test of the header/length/checksum deframer. Directed frames,
// register settings and random frame traffic are driven through the byte
// channel with random gaps and result stalls. A behavioral parser computes
// every result, and results are checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 7;
	localparam int RANDOM_BYTES   = 630;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int IDX_W          = hlcd_pkg::CFG_IDX_W;
	localparam int OUT_W          = hlcd_pkg::CNT_OUT_W;
	localparam int CW             = hlcd_pkg::CNT_W;
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic [1:0] {HUNT, GET_LEN, GET_BODY} parse_phase_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [7:0]       payload_byte;
		logic [7:0]       payload_index;
		logic             frame_is_async;
		logic [7:0]       frame_length;
		logic [OUT_W-1:0] header_error_count;
		logic [OUT_W-1:0] length_error_count;
		logic [OUT_W-1:0] checksum_error_count;
	} frame_result_t;

	typedef logic [7:0] byte_seq_t [$];

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [7:0]       cfg_data;

	hlcd_byte_if   rx_if ();
	hlcd_result_if res_if ();

	header_length_checksum_deframer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// parser state mirrored by the predictor
	hlcd_pkg::cfg_t regs;
	parse_phase_t   ph;
	logic           kind_async;
	logic [7:0]     want_len;
	logic [7:0]     got_cnt;
	logic [7:0]     body_sum;
	logic [CW-1:0]  hdr_errs;
	logic [CW-1:0]  len_errs;
	logic [CW-1:0]  cks_errs;

	frame_result_t expected_results [$];
	bit src_gaps;
	bit sink_stalls;
	int bytes_sent;
	int results_seen;
	int mismatches;
	int quiet_cycles;
	int status_seen [8];

	always #(HALF_PERIOD) clk = ~clk;

	function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	function automatic frame_result_t parse_byte(input logic [7:0] b);
		frame_result_t r;
		r = '0;
		r.status = hlcd_pkg::ST_CONSUMED;
		case (ph)
			GET_LEN: begin
				if (b > regs.max_length) begin
					r.status = hlcd_pkg::ST_LEN_ERR;
					len_errs = bump(len_errs);
					ph = HUNT;
				end else begin
					want_len = b;
					got_cnt = '0;
					body_sum = '0;
					ph = GET_BODY;
				end
			end
			GET_BODY: begin
				if (got_cnt == want_len) begin
					ph = HUNT;
					if (body_sum == b) begin
						r.status = hlcd_pkg::ST_GOOD;
					end else begin
						r.status = hlcd_pkg::ST_CKS_ERR;
						cks_errs = bump(cks_errs);
					end
				end else begin
					r.status = hlcd_pkg::ST_PAYLOAD;
					r.payload_byte = b;
					r.payload_index = got_cnt;
					body_sum = body_sum + b;
					got_cnt = got_cnt + 8'd1;
				end
			end
			default: begin
				if (b == regs.sync_header) begin
					kind_async = 1'b0;
					ph = GET_LEN;
				end else if (b == regs.async_header) begin
					kind_async = 1'b1;
					ph = GET_LEN;
				end else begin
					r.status = hlcd_pkg::ST_HDR_ERR;
					hdr_errs = bump(hdr_errs);
					ph = HUNT;
				end
			end
		endcase
		r.frame_is_async = kind_async;
		r.frame_length = want_len;
		r.header_error_count = OUT_W'(hdr_errs);
		r.length_error_count = OUT_W'(len_errs);
		r.checksum_error_count = OUT_W'(cks_errs);
		return r;
	endfunction

	function automatic string describe(input frame_result_t r);
		return $sformatf("st=%0d byte=%02h idx=%0d async=%0b len=%0d hdr=%0d lenerr=%0d cks=%0d",
			r.status, r.payload_byte, r.payload_index, r.frame_is_async, r.frame_length,
			r.header_error_count, r.length_error_count, r.checksum_error_count);
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at result %0d: %s", results_seen, what);
	endtask

	task automatic push_byte(input logic [7:0] b);
		int gap;
		gap = src_gaps ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		// ready is stable between edges, so look at it mid-cycle
		@(negedge clk);
		while (!rx_if.ready) @(negedge clk);
		@(posedge clk);
		expected_results.push_back(parse_byte(b));
		bytes_sent++;
	endtask

	task automatic push_seq(input byte_seq_t seq);
		foreach (seq[i]) push_byte(seq[i]);
	endtask

	task automatic drain_results();
		rx_if.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [7:0] val);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			hlcd_pkg::REG_SYNC_HEADER:  regs.sync_header = val;
			hlcd_pkg::REG_ASYNC_HEADER: regs.async_header = val;
			hlcd_pkg::REG_MAX_LENGTH:   regs.max_length = val;
			default: ;
		endcase
	endtask

	task automatic send_frame(input bit as_async, input int len, input bit bad_sum);
		logic [7:0] sum;
		logic [7:0] b;
		int i;
		sum = '0;
		push_byte(as_async ? regs.async_header : regs.sync_header);
		push_byte(8'(len));
		for (i = 0; i < len; i++) begin
			b = 8'($urandom);
			sum = sum + b;
			push_byte(b);
		end
		push_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic shuffle_regs();
		logic [7:0] lim;
		write_reg(hlcd_pkg::REG_SYNC_HEADER, pick_byte());
		write_reg(hlcd_pkg::REG_ASYNC_HEADER,
			($urandom_range(0, 9) == 0) ? regs.sync_header : pick_byte());
		case ($urandom_range(0, 3))
			0: lim = 8'h00;
			1: lim = 8'hFF;
			2: lim = 8'($urandom_range(1, 20));
			default: lim = 8'($urandom);
		endcase
		write_reg(hlcd_pkg::REG_MAX_LENGTH, lim);
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_UNUSED, 8'($urandom));
	endtask

	// frames with byte extremes, zero length, checksum wrap and bad headers
	task automatic test_directed_frames();
		src_gaps = 1'b1;
		sink_stalls = 1'b1;
		push_seq('{hlcd_pkg::SYNC_HDR_DEFAULT, 8'h03, 8'h00, 8'hFF, 8'h80, 8'h7F});
		push_seq('{hlcd_pkg::ASYNC_HDR_DEFAULT, 8'h00, 8'h00});
		push_seq('{hlcd_pkg::SYNC_HDR_DEFAULT, 8'h00, 8'h01});
		push_seq('{8'h00, 8'hFF});
		push_seq('{hlcd_pkg::ASYNC_HDR_DEFAULT, 8'h02, 8'hFF, 8'hFF, 8'h00});
	endtask

	task automatic test_register_settings();
		int i;
		write_reg(hlcd_pkg::REG_MAX_LENGTH, 8'd4);
		push_seq('{hlcd_pkg::SYNC_HDR_DEFAULT, 8'd5});
		send_frame(1'b0, 4, 1'b0);
		write_reg(hlcd_pkg::REG_SYNC_HEADER, 8'h00);
		write_reg(hlcd_pkg::REG_ASYNC_HEADER, 8'hFF);
		push_seq('{8'h00, 8'h01, 8'h07, 8'h07});
		push_seq('{8'hFF, 8'h00, 8'h00, hlcd_pkg::SYNC_HDR_DEFAULT});
		write_reg(hlcd_pkg::REG_SYNC_HEADER, 8'hFF);
		write_reg(hlcd_pkg::REG_ASYNC_HEADER, 8'h00);
		send_frame(1'b0, 1, 1'b0);
		send_frame(1'b1, 2, 1'b0);
		// equal headers, sync kind wins
		write_reg(hlcd_pkg::REG_SYNC_HEADER, 8'h5A);
		write_reg(hlcd_pkg::REG_ASYNC_HEADER, 8'h5A);
		push_seq('{8'h5A, 8'h00, 8'h00});
		write_reg(REG_UNUSED, 8'h00);
		send_frame(1'b0, 0, 1'b0);
		write_reg(hlcd_pkg::REG_SYNC_HEADER, hlcd_pkg::SYNC_HDR_DEFAULT);
		write_reg(hlcd_pkg::REG_ASYNC_HEADER, hlcd_pkg::ASYNC_HDR_DEFAULT);
		// limit changed between header and length byte
		push_byte(hlcd_pkg::SYNC_HDR_DEFAULT);
		write_reg(hlcd_pkg::REG_MAX_LENGTH, 8'd0);
		push_byte(8'd1);
		send_frame(1'b1, 0, 1'b1);
		push_byte(hlcd_pkg::ASYNC_HDR_DEFAULT);
		write_reg(hlcd_pkg::REG_MAX_LENGTH, hlcd_pkg::MAX_LEN_DEFAULT);
		push_byte(8'd255);
		for (i = 0; i < 255; i++) push_byte(8'(i * 7));
		push_byte(8'h00);
		send_frame(1'b0, 255, 1'b0);
	endtask

	task automatic test_random_traffic();
		int target;
		int next_change;
		int pick;
		int len;
		int lim;
		int i;
		target = bytes_sent + RANDOM_BYTES;
		next_change = bytes_sent;
		while (bytes_sent < target) begin
			if (bytes_sent >= next_change) begin
				shuffle_regs();
				pick = $urandom_range(0, 3);
				src_gaps = pick[0];
				sink_stalls = pick[1];
				next_change = bytes_sent + $urandom_range(80, 200);
			end
			lim = (regs.max_length < 10) ? regs.max_length : 10;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, regs.max_length)
				: $urandom_range(0, lim);
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_frame($urandom_range(0, 1), len, 1'b0);
			end else if (pick < 80) begin
				send_frame($urandom_range(0, 1), len, 1'b1);
			end else if (pick < 88) begin
				repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
			end else if (pick < 94 && regs.max_length != 8'hFF) begin
				push_byte($urandom_range(0, 1) ? regs.async_header : regs.sync_header);
				push_byte(8'($urandom_range(regs.max_length + 1, 255)));
			end else begin
				// frame cut short, next header lands inside its body
				push_byte(regs.sync_header);
				push_byte(8'(len));
				for (i = 0; i < len / 2; i++) push_byte(8'($urandom));
			end
		end
	endtask

	// result checker
	initial begin
		frame_result_t got;
		frame_result_t want;
		int stall;
		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = sink_stalls ? $urandom_range(0, 15) : 0;
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			// valid and fields are stable between edges, so sample mid-cycle
			@(negedge clk);
			while (!res_if.valid) @(negedge clk);
			got.status = res_if.status;
			got.payload_byte = res_if.payload_byte;
			got.payload_index = res_if.payload_index;
			got.frame_is_async = res_if.frame_is_async;
			got.frame_length = res_if.frame_length;
			got.header_error_count = res_if.header_error_count;
			got.length_error_count = res_if.length_error_count;
			got.checksum_error_count = res_if.checksum_error_count;
			status_seen[got.status]++;
			if (expected_results.size() == 0) begin
				flag_mismatch({"no request pending, got ", describe(got)});
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status || got.payload_byte !== want.payload_byte ||
					got.payload_index !== want.payload_index ||
					got.frame_is_async !== want.frame_is_async ||
					got.frame_length !== want.frame_length ||
					got.header_error_count !== want.header_error_count ||
					got.length_error_count !== want.length_error_count ||
					got.checksum_error_count !== want.checksum_error_count)
					flag_mismatch({"expected ", describe(want), " / got ", describe(got)});
			end
			results_seen++;
			@(posedge clk);
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= hlcd_pkg::REG_SYNC_HEADER;
		cfg_data <= 8'h00;
		rx_if.valid <= 1'b0;
		rx_if.rx_byte <= 8'h00;
		regs.sync_header = hlcd_pkg::SYNC_HDR_DEFAULT;
		regs.async_header = hlcd_pkg::ASYNC_HDR_DEFAULT;
		regs.max_length = hlcd_pkg::MAX_LEN_DEFAULT;
		ph = HUNT;
		kind_async = 1'b0;
		want_len = '0;
		got_cnt = '0;
		body_sum = '0;
		hdr_errs = '0;
		len_errs = '0;
		cks_errs = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_register_settings();
		test_random_traffic();
		drain_results();
		repeat (8) @(posedge clk);
		$display("covered %0d bytes: %0d payload, %0d good frames, %0d checksum errors",
			bytes_sent, status_seen[hlcd_pkg::ST_PAYLOAD], status_seen[hlcd_pkg::ST_GOOD],
			status_seen[hlcd_pkg::ST_CKS_ERR]);
		$display("header errors %0d, length errors %0d, register changes mid-stream; %0d mismatches",
			status_seen[hlcd_pkg::ST_HDR_ERR], status_seen[hlcd_pkg::ST_LEN_ERR], mismatches);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
